[hdl/bda_pkg.sv]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Shared widths, constants, the stage word type and the decade extraction
// function used by the conversion pipeline and the character serialiser.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int unsigned NUM_DIGITS  = 5;
    localparam int unsigned VALUE_W     = 16;
    localparam int unsigned PAD_W       = 3;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned CHAR_W      = 6;
    localparam int unsigned POS_W       = 3;
    localparam int unsigned WORK_W      = 17;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    localparam logic [POS_W-1:0]  UNITS_POS  = 3'(NUM_DIGITS - 1);

    localparam logic [WORK_W-1:0] PLACE_VALUE [NUM_DIGITS] =
        '{17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1};

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

    typedef struct packed {
        digit_vec_t         digits;
        logic [POS_W-1:0]   start;
    } bda_word_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [WORK_W-1:0]  rest;
    } decade_t;

    // One decimal digit by parallel compares against the multiples of the
    // place value; the remainder is taken from the matching subtraction.
    function automatic decade_t decade_split(input logic [WORK_W-1:0] rest,
                                             input logic [WORK_W-1:0] place);
        decade_t            res;
        logic [WORK_W-1:0]  multiple;
        res.digit = '0;
        res.rest  = rest;
        multiple  = '0;
        for (int k = 1; k <= 9; k++) begin
            multiple = multiple + place;
            if (rest >= multiple) begin
                res.digit = DIGIT_W'(k);
                res.rest  = rest - multiple;
            end
        end
        return res;
    endfunction

endpackage

[hdl/bda_serialiser.sv]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII character serialiser
// Holds one converted number and hands out one character word per cycle
// unless m_ready stalls, from the first emitted position to the units digit.
// ----------------------------------------------------------------------------
module bda_serialiser (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  bda_pkg::bda_word_t              in_word,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bda_pkg::CHAR_W-1:0]      m_digit_char,
    output logic [bda_pkg::POS_W-1:0]       m_digit_index,
    output logic                            m_last
);

    logic                           ser_valid_reg;
    bda_pkg::digit_vec_t            ser_digits_reg;
    logic [bda_pkg::POS_W-1:0]      ser_pos_reg;
    logic [bda_pkg::POS_W-1:0]      ser_idx_reg;

    logic                           m_valid_reg;
    logic [bda_pkg::CHAR_W-1:0]     m_char_reg;
    logic [bda_pkg::POS_W-1:0]      m_index_reg;
    logic                           m_last_reg;

    logic                           out_load;
    logic                           ser_last;
    logic                           in_load;
    logic [bda_pkg::CHAR_W-1:0]     char_next;

    assign ser_last  = (ser_pos_reg == bda_pkg::UNITS_POS);
    assign out_load  = ser_valid_reg && (!m_valid_reg || m_ready);
    assign in_ready  = !ser_valid_reg || (out_load && ser_last);
    assign in_load   = in_valid && in_ready;
    assign char_next = bda_pkg::ASCII_ZERO
                     + {2'b00, ser_digits_reg[ser_pos_reg]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (in_load) begin
                ser_valid_reg <= 1'b1;
            end else if (out_load && ser_last) begin
                ser_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            ser_digits_reg <= in_word.digits;
            ser_pos_reg    <= in_word.start;
            ser_idx_reg    <= '0;
        end else if (out_load) begin
            ser_pos_reg <= ser_pos_reg + 3'd1;
            ser_idx_reg <= ser_idx_reg + 3'd1;
        end
        if (out_load) begin
            m_char_reg  <= char_next;
            m_index_reg <= ser_idx_reg;
            m_last_reg  <= ser_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_digit_char  = m_char_reg;
    assign m_digit_index = m_index_reg;
    assign m_last        = m_last_reg;

    // A character that is not the last one always has its successor pending.
    a_more_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> ser_valid_reg)
        else $error("non-final character without a pending successor");

    // Characters of one number carry consecutive indices.
    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && !m_last_reg)
            |=> (m_valid_reg && m_index_reg == $past(m_index_reg) + 3'd1))
        else $error("character index did not advance by one");

    // Only decimal digit characters leave the block.
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_char_reg >= 6'd48 && m_char_reg <= 6'd57))
        else $error("character outside the decimal digits");

    // A held number never points past the units digit.
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_valid_reg |-> (ser_pos_reg <= bda_pkg::UNITS_POS))
        else $error("serialiser position beyond the units digit");

endmodule

[hdl/binary_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// Binary to decimal ASCII unit
// Converts a 16-bit unsigned value to its decimal ASCII digits with leading
// zero suppression and a minimum digit count.
// ----------------------------------------------------------------------------
// Usage
// The s_ channel takes one word per number: s_value and s_min_digits, with
// s_min_digits above five acting as five. The m_ channel returns one word per
// character, most significant first: m_digit_char ('0' to '9'), m_digit_index
// (from 0) and m_last, high on the units digit. A number yields between one
// and five characters, the larger of its significant digit count and the
// minimum count.
// Four pipeline stages extract the digits (ten-thousands, thousands,
// hundreds, then tens and units with the first emitted position), followed
// by the serialiser and the output register. The serialiser emits one
// character per cycle while m_ready is high, and numbers follow each other
// without gaps.
// A stall on m_ready holds the output word and fills the pipeline; s_ready
// drops only once all stages are full. Reset empties every stage.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [bda_pkg::VALUE_W-1:0]     s_value,
    input  logic [bda_pkg::PAD_W-1:0]       s_min_digits,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [bda_pkg::CHAR_W-1:0]      m_digit_char,
    output logic [bda_pkg::POS_W-1:0]       m_digit_index,
    output logic                            m_last
);

    logic                           st1_valid_reg, st2_valid_reg;
    logic                           st3_valid_reg, st4_valid_reg;
    logic                           en1, en2, en3, en4;
    logic                           ser_ready;

    bda_pkg::digit_vec_t            st1_digits_reg, st2_digits_reg, st3_digits_reg;
    logic [13:0]                    st1_rest_reg;
    logic [9:0]                     st2_rest_reg;
    logic [6:0]                     st3_rest_reg;
    logic [bda_pkg::PAD_W-1:0]      st1_pad_reg, st2_pad_reg, st3_pad_reg;
    bda_pkg::bda_word_t             st4_word_reg;

    logic [bda_pkg::PAD_W-1:0]      pad_next;
    bda_pkg::decade_t               dec1, dec2, dec3, dec4;
    bda_pkg::digit_vec_t            digits1_next, digits2_next, digits3_next;
    bda_pkg::digit_vec_t            digits4_next;
    logic [bda_pkg::POS_W-1:0]      start_next;

    assign en4     = !st4_valid_reg || ser_ready;
    assign en3     = !st3_valid_reg || en4;
    assign en2     = !st2_valid_reg || en3;
    assign en1     = !st1_valid_reg || en2;
    assign s_ready = en1;

    assign pad_next = (s_min_digits > bda_pkg::PAD_W'(bda_pkg::NUM_DIGITS))
                    ? bda_pkg::PAD_W'(bda_pkg::NUM_DIGITS) : s_min_digits;

    assign dec1 = bda_pkg::decade_split({1'b0, s_value}, bda_pkg::PLACE_VALUE[0]);
    assign dec2 = bda_pkg::decade_split(17'(st1_rest_reg), bda_pkg::PLACE_VALUE[1]);
    assign dec3 = bda_pkg::decade_split(17'(st2_rest_reg), bda_pkg::PLACE_VALUE[2]);
    assign dec4 = bda_pkg::decade_split(17'(st3_rest_reg), bda_pkg::PLACE_VALUE[3]);

    always_comb begin
        digits1_next    = '0;
        digits1_next[0] = dec1.digit;
        digits2_next    = st1_digits_reg;
        digits2_next[1] = dec2.digit;
        digits3_next    = st2_digits_reg;
        digits3_next[2] = dec3.digit;
        digits4_next    = st3_digits_reg;
        digits4_next[3] = dec4.digit;
        digits4_next[4] = dec4.rest[bda_pkg::DIGIT_W-1:0];
        start_next      = bda_pkg::UNITS_POS;
        for (int k = bda_pkg::NUM_DIGITS - 1; k >= 0; k--) begin
            if ((bda_pkg::PAD_W'(bda_pkg::NUM_DIGITS - k) <= st3_pad_reg)
                    || (digits4_next[k] != '0)) begin
                start_next = bda_pkg::POS_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                st1_valid_reg <= s_valid;
            end
            if (en2) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (en3) begin
                st3_valid_reg <= st2_valid_reg;
            end
            if (en4) begin
                st4_valid_reg <= st3_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            st1_digits_reg <= digits1_next;
            st1_rest_reg   <= dec1.rest[13:0];
            st1_pad_reg    <= pad_next;
        end
        if (en2) begin
            st2_digits_reg <= digits2_next;
            st2_rest_reg   <= dec2.rest[9:0];
            st2_pad_reg    <= st1_pad_reg;
        end
        if (en3) begin
            st3_digits_reg <= digits3_next;
            st3_rest_reg   <= dec3.rest[6:0];
            st3_pad_reg    <= st2_pad_reg;
        end
        if (en4) begin
            st4_word_reg.digits <= digits4_next;
            st4_word_reg.start  <= start_next;
        end
    end

    bda_serialiser u_serialiser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (st4_valid_reg),
        .in_ready      (ser_ready),
        .in_word       (st4_word_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digit_char  (m_digit_char),
        .m_digit_index (m_digit_index),
        .m_last        (m_last)
    );

    // A full pipeline with a willing serialiser must still accept a word.
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_ready |-> s_ready)
        else $error("input stalled while the serialiser can take a word");

    // A word stalled in the last stage keeps its contents.
    a_stage4_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (st4_valid_reg && !ser_ready) |=> (st4_valid_reg && $stable(st4_word_reg)))
        else $error("last pipeline stage changed while stalled");

    // Tens and units digits are always decimal.
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st4_valid_reg |-> (st4_word_reg.digits[3] <= 4'd9
                           && st4_word_reg.digits[4] <= 4'd9))
        else $error("digit outside the decimal range");

endmodule
